// ===== hdl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared width default and the command and status bundles that pass between
// the sequencer and the arithmetic datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // Default operand width of the base, exponent, modulus and result.
    localparam int OPERAND_WIDTH_DEF = 32;

    // Commands from the sequencer to the datapath, one bit per operation.
    typedef struct packed {
        logic load;        // capture a new transaction
        logic red_step;    // one restoring-remainder step of the base reduction
        logic red_fix;     // finish the base reduction, preset the running result
        logic mul_load_r;  // start the product result * base
        logic mul_load_b;  // start the square base * base
        logic mul_step;    // one shift-and-add step of the modular product
        logic wb_r;        // write the product back into the running result
        logic wb_b;        // write the square back into the base, next exponent bit
        logic finish;      // present the result for one cycle
    } mexp_cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic mod_zero;    // captured modulus is zero
        logic exp_lsb;     // current exponent bit
    } mexp_stat_t;

endpackage

// ===== hdl/mexp_datapath.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Operand registers, a bit-serial remainder unit for the base reduction and a
// shared bit-serial shift-and-add multiplier-reducer for the modular products.
// ----------------------------------------------------------------------------
module mexp_datapath #(
    parameter int W = mexp_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mexp_pkg::mexp_cmd_t       cmd,
    output mexp_pkg::mexp_stat_t      stat,
    input  logic signed [W-1:0]       base_value,
    input  logic        [W-1:0]       exponent,
    input  logic        [W-1:0]       modulus,
    output logic        [W-1:0]       power_result,
    output logic                      modulus_zero,
    output logic                      done
);

    import mexp_pkg::*;

    logic [W-1:0] mod_reg;
    logic [W-1:0] exp_reg;
    logic         neg_reg;
    logic [W-1:0] r_reg;
    logic [W-1:0] b_reg;
    logic [W-1:0] a_reg;
    logic [W-1:0] mpl_reg;
    logic [W-1:0] acc_reg;
    logic [W-1:0] power_result_reg;
    logic         modulus_zero_reg;
    logic         done_reg;

    logic [W-1:0] base_bits;
    logic [W-1:0] base_mag;
    logic [W:0]   red_trial;
    logic [W-1:0] red_next;
    logic [W:0]   dbl;
    logic [W-1:0] dbl_red;
    logic [W:0]   sum;
    logic [W-1:0] sum_red;
    logic [W-1:0] mul_next;
    logic [W-1:0] neg_fix;

    // Magnitude of the two's complement base; the most negative value maps
    // onto its unsigned magnitude.
    assign base_bits = base_value;
    assign base_mag  = base_bits[W-1] ? (~base_bits + W'(1)) : base_bits;

    // Restoring remainder step: bring in the next magnitude bit.
    assign red_trial = {acc_reg, mpl_reg[W-1]};
    assign red_next  = (red_trial >= {1'b0, mod_reg}) ?
                       W'(red_trial - {1'b0, mod_reg}) : W'(red_trial);

    // A negative base with a nonzero remainder lands at modulus minus remainder.
    assign neg_fix = (neg_reg && (acc_reg != '0)) ? (mod_reg - acc_reg) : acc_reg;

    // Multiplier-reducer step: double, then add the multiplicand if the
    // current multiplier bit is set, each followed by one conditional subtract.
    assign dbl      = {acc_reg, 1'b0};
    assign dbl_red  = (dbl >= {1'b0, mod_reg}) ? W'(dbl - {1'b0, mod_reg}) : W'(dbl);
    assign sum      = {1'b0, dbl_red} + {1'b0, a_reg};
    assign sum_red  = (sum >= {1'b0, mod_reg}) ? W'(sum - {1'b0, mod_reg}) : W'(sum);
    assign mul_next = mpl_reg[W-1] ? sum_red : dbl_red;

    // Operand and working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mod_reg <= modulus;
            exp_reg <= exponent;
            neg_reg <= base_bits[W-1];
            mpl_reg <= base_mag;
            acc_reg <= '0;
        end
        if (cmd.red_step)
        begin
            acc_reg <= red_next;
            mpl_reg <= {mpl_reg[W-2:0], 1'b0};
        end
        if (cmd.red_fix)
        begin
            b_reg <= neg_fix;
            r_reg <= (mod_reg == W'(1)) ? '0 : W'(1);
        end
        if (cmd.mul_load_r)
        begin
            a_reg   <= r_reg;
            mpl_reg <= b_reg;
            acc_reg <= '0;
        end
        if (cmd.mul_load_b)
        begin
            a_reg   <= b_reg;
            mpl_reg <= b_reg;
            acc_reg <= '0;
        end
        if (cmd.mul_step)
        begin
            acc_reg <= mul_next;
            mpl_reg <= {mpl_reg[W-2:0], 1'b0};
        end
        if (cmd.wb_r)
        begin
            r_reg <= acc_reg;
        end
        if (cmd.wb_b)
        begin
            b_reg   <= acc_reg;
            exp_reg <= {1'b0, exp_reg[W-1:1]};
        end
        if (cmd.finish)
        begin
            power_result_reg <= (mod_reg == '0) ? '0 : r_reg;
            modulus_zero_reg <= (mod_reg == '0);
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    assign stat.mod_zero = (mod_reg == '0);
    assign stat.exp_lsb  = exp_reg[0];

    assign power_result = power_result_reg;
    assign modulus_zero = modulus_zero_reg;
    assign done         = done_reg;

endmodule

// ===== hdl/mexp_controller.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation sequencer
// One-hot state machine that steps the base reduction, then walks the
// exponent bits right to left, issuing a multiply for each set bit and a
// square for every bit.
// ----------------------------------------------------------------------------
module mexp_controller #(
    parameter int W = mexp_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  mexp_pkg::mexp_stat_t  stat,
    output mexp_pkg::mexp_cmd_t   cmd
);

    import mexp_pkg::*;

    localparam int CW = $clog2(W);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_CHECK  = 11'b000_0000_0010,
        S_REDUCE = 11'b000_0000_0100,
        S_FIX    = 11'b000_0000_1000,
        S_SEL    = 11'b000_0001_0000,
        S_MUL_R  = 11'b000_0010_0000,
        S_WB_R   = 11'b000_0100_0000,
        S_SQ     = 11'b000_1000_0000,
        S_MUL_B  = 11'b001_0000_0000,
        S_WB_B   = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    logic [CW-1:0]   ecnt_reg;
    logic [CW-1:0]   ecnt_next;

    // Next-state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ecnt_next  = ecnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cnt_next   = CW'(W - 1);
                state_next = stat.mod_zero ? S_DONE : S_REDUCE;
            end
            S_REDUCE:
            begin
                cmd.red_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_FIX;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            S_FIX:
            begin
                cmd.red_fix = 1'b1;
                ecnt_next   = CW'(W - 1);
                state_next  = S_SEL;
            end
            S_SEL:
            begin
                cnt_next = CW'(W - 1);
                if (stat.exp_lsb)
                begin
                    cmd.mul_load_r = 1'b1;
                    state_next     = S_MUL_R;
                end
                else
                begin
                    cmd.mul_load_b = 1'b1;
                    state_next     = S_MUL_B;
                end
            end
            S_MUL_R:
            begin
                cmd.mul_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_WB_R;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            S_WB_R:
            begin
                cmd.wb_r   = 1'b1;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.mul_load_b = 1'b1;
                cnt_next       = CW'(W - 1);
                state_next     = S_MUL_B;
            end
            S_MUL_B:
            begin
                cmd.mul_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_WB_B;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            S_WB_B:
            begin
                cmd.wb_b = 1'b1;
                if (ecnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ecnt_next  = ecnt_reg - CW'(1);
                    state_next = S_SEL;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ecnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ecnt_reg  <= ecnt_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== hdl/modular_exponentiation_core.sv =====
// From an accepted start to the done strobe the core reduces the base, then squares for
// every exponent bit and multiplies for each set bit, all skipped for a zero modulus;
// one transaction at a time, busy high meanwhile. The cost is set by the single
// bit-serial multiplier-reducer, one bit per cycle. Reset (rst_n, asynchronous, active
// low) returns the sequencer to idle and drops done; a result is shown for one cycle
// with done and cannot be stalled.
// ----------------------------------------------------------------------------
// Modular exponentiation core
// Computes base to the power exponent modulo modulus by right-to-left
// square-and-multiply; a zero modulus returns zero and raises modulus_zero.
// ----------------------------------------------------------------------------
module modular_exponentiation_core #(
    parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [OPERAND_WIDTH-1:0] base_value,
    input  logic        [OPERAND_WIDTH-1:0] exponent,
    input  logic        [OPERAND_WIDTH-1:0] modulus,
    output logic        [OPERAND_WIDTH-1:0] power_result,
    output logic                            modulus_zero,
    output logic                            done
);

    import mexp_pkg::*;

    mexp_cmd_t  cmd;
    mexp_stat_t stat;

    // Sequencer.
    mexp_controller #(
        .W (OPERAND_WIDTH)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Arithmetic datapath.
    mexp_datapath #(
        .W (OPERAND_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .base_value   (base_value),
        .exponent     (exponent),
        .modulus      (modulus),
        .power_result (power_result),
        .modulus_zero (modulus_zero),
        .done         (done)
    );

`ifndef SYNTHESIS
    // A result is only presented once the sequencer is back in idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done asserted while busy");

    // An invalid modulus always reports a zero result.
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && modulus_zero) |-> (power_result == '0))
        else $error("nonzero result with zero modulus");

    // An accepted transaction makes the core busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transaction accepted but core not busy");

    // The result strobe lasts a single cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");
`endif

endmodule

// ===== dv/modular_exponentiation_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular exponentiation core testbench
// Drives directed corner cases and then random operand sets through the
// start/busy command port, with random gaps between transactions. Each
// accepted transaction is predicted with exact 64-bit modular arithmetic,
// and every done strobe is checked in order against the oldest prediction.
// ----------------------------------------------------------------------------
module modular_exponentiation_core_test;

    localparam int W          = mexp_pkg::OPERAND_WIDTH_DEF;
    localparam int RANDOM_OPS = 275;
    localparam int DRAIN_WAIT = 2400;
    localparam int CYCLE_CAP  = 4_000_000;
    localparam int SHOW_MAX   = 10;

    // One operand set as presented on the command port.
    typedef struct {
        logic signed [W-1:0] base;
        logic        [W-1:0] exp;
        logic        [W-1:0] modulus;
    } operands_t;

    // Predicted outcome of one transaction, with its operands for reporting.
    typedef struct {
        operands_t   ops;
        logic [W-1:0] power;
        logic         mod_zero;
    } power_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                start        = 1'b0;
    logic signed [W-1:0] base_value   = '0;
    logic        [W-1:0] exponent     = '0;
    logic        [W-1:0] modulus      = '0;
    logic                busy;
    logic        [W-1:0] power_result;
    logic                modulus_zero;
    logic                done;

    operands_t operand_queue[$];
    power_t    expected_powers[$];
    int        ops_total      = 0;
    int        ops_accepted   = 0;
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        gap_left       = 0;
    bit        start_taken    = 1'b0;
    operands_t next_ops;
    power_t    seen;

    modular_exponentiation_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .base_value   (base_value),
        .exponent     (exponent),
        .modulus      (modulus),
        .power_result (power_result),
        .modulus_zero (modulus_zero),
        .done         (done)
    );

    always #5 clk = ~clk;

    // Product of two residues below the modulus; the double-width product is exact.
    function automatic logic [W-1:0] mul_reduce(logic [W-1:0] a, logic [W-1:0] b,
                                                 logic [W-1:0] m);
        logic [2*W-1:0] prod;
        prod = {{W{1'b0}}, a} * {{W{1'b0}}, b};
        return W'(prod % {{W{1'b0}}, m});
    endfunction

    // Base raised to the exponent modulo the modulus, right-to-left binary method.
    function automatic power_t predict_modpow(operands_t ops);
        power_t       res;
        logic [W-1:0] mag;
        logic [W-1:0] sq;
        logic [W-1:0] acc;
        res.ops = ops;
        if (ops.modulus == '0) begin
            res.power    = '0;
            res.mod_zero = 1'b1;
            return res;
        end
        // A negative base is folded into 0 .. modulus-1 through its magnitude.
        if (ops.base[W-1]) begin
            mag = (~ops.base + 1'b1) % ops.modulus;
            sq  = (mag == '0) ? '0 : ops.modulus - mag;
        end else begin
            sq = ops.base % ops.modulus;
        end
        acc = (ops.modulus == 1) ? '0 : 1;
        for (int i = 0; i < W; i++) begin
            if (ops.exp[i])
                acc = mul_reduce(acc, sq, ops.modulus);
            sq = mul_reduce(sq, sq, ops.modulus);
        end
        res.power    = acc;
        res.mod_zero = 1'b0;
        return res;
    endfunction

    task automatic add_op(logic signed [W-1:0] b, logic [W-1:0] e, logic [W-1:0] m);
        operands_t ops;
        ops.base    = b;
        ops.exp     = e;
        ops.modulus = m;
        operand_queue.push_back(ops);
        ops_total++;
    endtask

    task automatic note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= SHOW_MAX)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Run length guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP) begin
            $display("modular_exponentiation_core test failed");
            $finish;
        end
    end

    // Monitor: check each done strobe, then record the transaction accepted at this edge.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            start_taken = 1'b0;
        end else begin
            if (done) begin
                if (expected_powers.size() == 0) begin
                    note_mismatch($sformatf("unexpected result power=%h flag=%0b",
                                            power_result, modulus_zero));
                end else begin
                    seen = expected_powers.pop_front();
                    if (power_result !== seen.power)
                        note_mismatch($sformatf(
                            "power_result base=%h exp=%h mod=%h expected %h got %h",
                            seen.ops.base, seen.ops.exp, seen.ops.modulus,
                            seen.power, power_result));
                    if (modulus_zero !== seen.mod_zero)
                        note_mismatch($sformatf(
                            "modulus_zero base=%h exp=%h mod=%h expected %0b got %0b",
                            seen.ops.base, seen.ops.exp, seen.ops.modulus,
                            seen.mod_zero, modulus_zero));
                end
            end
            start_taken = start && !busy;
            if (start_taken) begin
                next_ops.base    = base_value;
                next_ops.exp     = exponent;
                next_ops.modulus = modulus;
                expected_powers.push_back(predict_modpow(next_ops));
                ops_accepted++;
            end
        end
    end

    // Driver: hold a pending transaction until accepted, otherwise idle or issue the next.
    always @(negedge clk)
    begin
        if (rst_n && !(start && !start_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                start      <= 1'b0;
                base_value <= $urandom;
                exponent   <= $urandom;
                modulus    <= $urandom;
            end else if (operand_queue.size() > 0) begin
                next_ops = operand_queue.pop_front();
                start      <= 1'b1;
                base_value <= next_ops.base;
                exponent   <= next_ops.exp;
                modulus    <= next_ops.modulus;
                // Mostly back-to-back, sometimes short pauses, rarely a pause
                // long enough to land anywhere inside a computation.
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: gap_left = 0;
                    6, 7, 8:          gap_left = $urandom_range(1, 4);
                    default:          gap_left = $urandom_range(5, 2400);
                endcase
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Stimulus and end of test.
    initial
    begin
        logic signed [W-1:0] b;
        logic        [W-1:0] e;
        logic        [W-1:0] m;
        int                  waited;

        // Zero modulus is flagged, whatever the other operands.
        add_op(32'h1234_5678, 32'h0000_0005, '0);
        add_op('0, '0, '0);
        add_op(32'h8000_0000, 32'hFFFF_FFFF, '0);
        // A unit modulus always yields zero, even with a zero exponent.
        add_op(5, 3, 1);
        add_op(-7, 0, 1);
        // A zero exponent yields one, also for a zero base; a zero base with a nonzero exponent yields zero.
        add_op(-3, 0, 7);
        add_op(0, 0, 13);
        add_op(0, 5, 13);
        // Most negative base, whose magnitude needs the full unsigned width.
        add_op(32'h8000_0000, 3, 1_000_003);
        add_op(32'h8000_0000, 1, 32'h8000_0000);
        // Full-scale operands.
        add_op(-1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_op(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_op(32'h7FFF_FFFF, 2, 32'hFFFF_FFFF);
        add_op(-1, 1, 2);
        // Negative multiple of the modulus reduces to zero; another negative base lands at modulus minus remainder.
        add_op(-14, 9, 7);
        add_op(-5, 1, 3);
        // Fermat check against the largest 32-bit prime, and a large even modulus.
        add_op(2, 32'hFFFF_FFFA, 32'hFFFF_FFFB);
        add_op(3, 32'h8000_0001, 32'hFFFF_FFFE);

        // Random operand sets with a bias toward the interesting regions.
        for (int n = 0; n < RANDOM_OPS; n++) begin
            case ($urandom_range(0, 19))
                0:             m = '0;
                1:             m = 1;
                2, 3, 4, 5, 6: m = $urandom_range(2, 255);
                7, 8:          m = W'(1) << $urandom_range(1, W - 1);
                9, 10:         m = 32'hFFFF_FFFF - $urandom_range(0, 64);
                default:       m = $urandom;
            endcase
            case ($urandom_range(0, 9))
                0: b = $urandom_range(0, 32) - 16;
                1: begin
                    case ($urandom_range(0, 3))
                        0:       b = 32'h8000_0000;
                        1:       b = 32'h7FFF_FFFF;
                        2:       b = -1;
                        default: b = '0;
                    endcase
                end
                2: begin
                    b = m * $urandom_range(0, 3);
                    if ($urandom_range(0, 1))
                        b = -b;
                end
                default: b = $urandom;
            endcase
            case ($urandom_range(0, 9))
                0:       e = '0;
                1:       e = 32'hFFFF_FFFF;
                2:       e = $urandom_range(1, 16);
                3:       e = W'(1) << $urandom_range(0, W - 1);
                default: e = $urandom;
            endcase
            add_op(b, e, m);
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every transaction to be accepted and answered.
        while (ops_accepted < ops_total || expected_powers.size() != 0)
            @(posedge clk);

        // Let a full computation time pass to catch any stray strobe.
        waited = 0;
        while (waited < DRAIN_WAIT) begin
            @(posedge clk);
            waited++;
        end

        if (mismatch_count == 0 && expected_powers.size() == 0)
            $display("modular_exponentiation_core test passed");
        else
            $display("modular_exponentiation_core test failed");
        $finish;
    end

endmodule
